// ----- design/sdv_pkg.sv -----
// ----------------------------------------------------------------------------
// sdv_pkg: shared types and helpers for the spring-damper velocity step
// Item structs, status codes, reset value and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sdv_pkg;

    localparam int unsigned TS_W = 31;
    localparam logic [TS_W-1:0] TIME_SCALE_RESET = 31'd6554;

    localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
    localparam logic signed [64:0] SAT_LO = -65'sd2147483648;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_LEN  = 2'd1,
        ST_ZERO_MASS = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [31:0] rel_vel_x;
        logic signed [31:0] rel_vel_y;
        logic [30:0]        rest_length;
        logic [30:0]        stiffness;
        logic [30:0]        damping;
        logic [30:0]        mass_a;
        logic [30:0]        mass_b;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] dvel_a_x;
        logic signed [31:0] dvel_a_y;
        logic signed [31:0] dvel_b_x;
        logic signed [31:0] dvel_b_y;
        t_status            status;
    } t_out_item;

    // clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] res;
        if (v > SAT_HI) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // apply sign to a quotient magnitude and clamp to 32 bits
    function automatic logic signed [31:0] sat_mag(input logic [47:0] q, input logic neg);
        logic signed [31:0] res;
        if (neg) begin
            if (q > 48'd2147483648) begin
                res = 32'sh8000_0000;
            end else begin
                res = -q[31:0];
            end
        end else begin
            if (q > 48'd2147483647) begin
                res = 32'sh7FFF_FFFF;
            end else begin
                res = q[31:0];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- design/sdv_sqrt.sv -----
// ----------------------------------------------------------------------------
// sdv_sqrt: pipelined integer square root
// One root bit per stage, floor result, side data carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module sdv_sqrt #(
    parameter int WR = 32,
    parameter int WS = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_v,
    input  logic [2*WR-1:0] i_rad,
    input  logic [WS-1:0]   i_side,
    output logic            o_v,
    output logic [WR-1:0]   o_root,
    output logic [WS-1:0]   o_side
);

    logic            w_v    [0:WR];
    logic [2*WR-1:0] w_rad  [0:WR];
    logic [WR+1:0]   w_rem  [0:WR];
    logic [WR-1:0]   w_root [0:WR];
    logic [WS-1:0]   w_side [0:WR];

    assign w_v[0]    = i_v;
    assign w_rad[0]  = i_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < WR; k++) begin : g_stage
        logic [WR+1:0]   w_cur;
        logic [WR+1:0]   w_trial;
        logic            w_ge;
        logic            r_v;
        logic [2*WR-1:0] r_rad;
        logic [WR+1:0]   r_rem;
        logic [WR-1:0]   r_root;
        logic [WS-1:0]   r_side;

        // partial remainder stays below 2^WR before the shift
        assign w_cur   = {w_rem[k][WR-1:0], w_rad[k][2*WR-1 -: 2]};
        assign w_trial = {w_root[k], 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad  <= {w_rad[k][2*WR-3:0], 2'b00};
                r_rem  <= w_ge ? (w_cur - w_trial) : w_cur;
                r_root <= {w_root[k][WR-2:0], w_ge};
                r_side <= w_side[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_rad[k+1]  = r_rad;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_side[k+1] = r_side;
    end

    assign o_v    = w_v[WR];
    assign o_root = w_root[WR];
    assign o_side = w_side[WR];

endmodule

`default_nettype wire

// ----- design/sdv_div.sv -----
// ----------------------------------------------------------------------------
// sdv_div: pipelined unsigned restoring divider
// One quotient bit per stage, side data carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module sdv_div #(
    parameter int WN = 48,
    parameter int WD = 32,
    parameter int WS = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_v,
    input  logic [WN-1:0] i_num,
    input  logic [WD-1:0] i_den,
    input  logic [WS-1:0] i_side,
    output logic          o_v,
    output logic [WN-1:0] o_quo,
    output logic [WS-1:0] o_side
);

    logic          w_v    [0:WN];
    logic [WN-1:0] w_num  [0:WN];
    logic [WD-1:0] w_rem  [0:WN];
    logic [WD-1:0] w_den  [0:WN];
    logic [WS-1:0] w_side [0:WN];

    assign w_v[0]    = i_v;
    assign w_num[0]  = i_num;
    assign w_rem[0]  = '0;
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < WN; k++) begin : g_stage
        logic [WD:0]   w_trial;
        logic [WD-1:0] w_diff;
        logic          w_ge;
        logic          r_v;
        logic [WN-1:0] r_num;
        logic [WD-1:0] r_rem;
        logic [WD-1:0] r_den;
        logic [WS-1:0] r_side;

        assign w_trial = {w_rem[k], w_num[k][WN-1]};
        assign w_ge    = (w_trial >= {1'b0, w_den[k]});
        // true difference is below the divisor, so WD bits hold it
        assign w_diff  = w_trial[WD-1:0] - w_den[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        // numerator shifts out at the top, quotient bits shift in at the bottom
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num  <= {w_num[k][WN-2:0], w_ge};
                r_rem  <= w_ge ? w_diff : w_trial[WD-1:0];
                r_den  <= w_den[k];
                r_side <= w_side[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_num[k+1]  = r_num;
        assign w_rem[k+1]  = r_rem;
        assign w_den[k+1]  = r_den;
        assign w_side[k+1] = r_side;
    end

    assign o_v    = w_v[WN];
    assign o_quo  = w_num[WN];
    assign o_side = w_side[WN];

endmodule

`default_nettype wire

// ----- design/spring_damper_velocity_step.sv -----
// ----------------------------------------------------------------------------
// spring_damper_velocity_step: velocity deltas of one spring-damper
// Length, direction, spring and damping impulse, per-end velocity changes.
// ----------------------------------------------------------------------------
// Takes one spring per cycle and returns the velocity changes of its two ends,
// one item out for every item in, in order. All values are Q16.16. The block is
// a single pipeline of 138 stages: squares and sum (2), a square root at one
// root bit per stage (32), the direction divide at one quotient bit per stage
// (48), seven multiply/shift/saturate stages, the mass divides (48, four
// dividers side by side) and the output register. Throughput is one item per
// cycle while the output is not stalled. Backpressure freezes the whole
// pipeline while the output item waits, so the input is still taken whenever
// the output register is empty or being drained. Zero length reports status 1,
// zero mass status 2, both with zero deltas. time_scale must be written through
// i_cfg_we / i_cfg_data only while the block is idle; nothing here enforces it.
// ----------------------------------------------------------------------------
`default_nettype none

module spring_damper_velocity_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sdv_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sdv_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_data
);

    // context carried through the multiply stages
    typedef struct packed {
        sdv_pkg::t_status   status;
        logic signed [17:0] n_x;
        logic signed [17:0] n_y;
        logic [30:0]        damping;
        logic [30:0]        stiffness;
        logic [30:0]        mass_a;
        logic [30:0]        mass_b;
    } t_ctx;

    localparam int ITEM_W = $bits(sdv_pkg::t_in_item);

    logic w_adv;   // whole pipeline advances
    logic r_out_v;
    sdv_pkg::t_out_item r_out_item;
    logic [30:0] r_ts;

    assign w_adv       = !r_out_v || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out_item;

    // time_scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts <= sdv_pkg::TIME_SCALE_RESET;
        end else if (i_cfg_we) begin
            r_ts <= i_cfg_data;
        end
    end

    // ---- stage 1: squares of the position difference ----
    logic               r1_v;
    sdv_pkg::t_in_item  r1_item;
    logic signed [63:0] r1_sqx, r1_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_item <= i_in_item;
            r1_sqx  <= i_in_item.delta_x * i_in_item.delta_x;
            r1_sqy  <= i_in_item.delta_y * i_in_item.delta_y;
        end
    end

    // ---- stage 2: sum of squares (max 2^63, fits unsigned 64) ----
    logic              r2_v;
    sdv_pkg::t_in_item r2_item;
    logic [63:0]       r2_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_item <= r1_item;
            r2_sq   <= $unsigned(r1_sqx) + $unsigned(r1_sqy);
        end
    end

    // ---- square root: spring length ----
    logic              w_sq_v;
    logic [31:0]       w_len;
    logic [ITEM_W-1:0] w_sq_side;
    sdv_pkg::t_in_item w_sq_item;

    sdv_sqrt #(
        .WR (32),
        .WS (ITEM_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_v     (r2_v),
        .i_rad   (r2_sq),
        .i_side  (r2_item),
        .o_v     (w_sq_v),
        .o_root  (w_len),
        .o_side  (w_sq_side)
    );

    assign w_sq_item = sdv_pkg::t_in_item'(w_sq_side);

    // ---- direction divide: |d| * 2^16 / L, sign applied afterwards ----
    logic [31:0] w_adx, w_ady;

    assign w_adx = w_sq_item.delta_x[31] ? 32'(-w_sq_item.delta_x) : 32'(w_sq_item.delta_x);
    assign w_ady = w_sq_item.delta_y[31] ? 32'(-w_sq_item.delta_y) : 32'(w_sq_item.delta_y);

    logic              w_ndx_v, w_ndy_v;
    logic [47:0]       w_qnx, w_qny;
    logic [ITEM_W-1:0] w_nd_side;
    logic [31:0]       w_nd_len;
    sdv_pkg::t_in_item w_nd_item;

    sdv_div #(
        .WN (48),
        .WD (32),
        .WS (ITEM_W)
    ) u_div_nx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_v     (w_sq_v),
        .i_num   ({w_adx, 16'h0000}),
        .i_den   (w_len),
        .i_side  (w_sq_side),
        .o_v     (w_ndx_v),
        .o_quo   (w_qnx),
        .o_side  (w_nd_side)
    );

    sdv_div #(
        .WN (48),
        .WD (32),
        .WS (32)
    ) u_div_ny (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_v     (w_sq_v),
        .i_num   ({w_ady, 16'h0000}),
        .i_den   (w_len),
        .i_side  (w_len),
        .o_v     (w_ndy_v),
        .o_quo   (w_qny),
        .o_side  (w_nd_len)
    );

    assign w_nd_item = sdv_pkg::t_in_item'(w_nd_side);

    // |n| <= 1.0, so the quotient fits 17 bits
    logic signed [17:0] w_nx, w_ny;
    logic signed [32:0] w_diff;
    sdv_pkg::t_status   w_status;

    assign w_nx   = w_nd_item.delta_x[31] ? -$signed(w_qnx[17:0]) : $signed(w_qnx[17:0]);
    assign w_ny   = w_nd_item.delta_y[31] ? -$signed(w_qny[17:0]) : $signed(w_qny[17:0]);
    assign w_diff = $signed({2'b00, w_nd_item.rest_length}) - $signed({1'b0, w_nd_len});

    always_comb begin
        if (w_nd_len == 32'd0) begin
            w_status = sdv_pkg::ST_ZERO_LEN;
        end else if (w_nd_item.mass_a == 31'd0 || w_nd_item.mass_b == 31'd0) begin
            w_status = sdv_pkg::ST_ZERO_MASS;
        end else begin
            w_status = sdv_pkg::ST_OK;
        end
    end

    // ---- stage 4: n.dv products and n*(rest-L) ----
    logic               r4_v;
    t_ctx               r4_ctx;
    logic signed [49:0] r4_px, r4_py;
    logic signed [50:0] r4_sx, r4_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_adv) begin
            r4_v <= w_ndx_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_ctx.status    <= w_status;
            r4_ctx.n_x       <= w_nx;
            r4_ctx.n_y       <= w_ny;
            r4_ctx.damping   <= w_nd_item.damping;
            r4_ctx.stiffness <= w_nd_item.stiffness;
            r4_ctx.mass_a    <= w_nd_item.mass_a;
            r4_ctx.mass_b    <= w_nd_item.mass_b;
            r4_px <= w_nx * w_nd_item.rel_vel_x;
            r4_py <= w_ny * w_nd_item.rel_vel_y;
            r4_sx <= w_nx * w_diff;
            r4_sy <= w_ny * w_diff;
        end
    end

    // ---- stage 5: rv and the half-scaled spring stretch ----
    logic signed [50:0] w5_sum, w5_rvs, w5_shx, w5_shy;
    logic               r5_v;
    t_ctx               r5_ctx;
    logic signed [31:0] r5_rv;
    logic signed [32:0] r5_shx, r5_shy;

    assign w5_sum = {r4_px[49], r4_px} + {r4_py[49], r4_py};
    assign w5_rvs = w5_sum >>> 16;
    // the extra bit of shift is the factor 0.5; |result| < 2^31
    assign w5_shx = r4_sx >>> 17;
    assign w5_shy = r4_sy >>> 17;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_adv) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_ctx <= r4_ctx;
            r5_rv  <= sdv_pkg::sat32({{14{w5_rvs[50]}}, w5_rvs});
            r5_shx <= w5_shx[32:0];
            r5_shy <= w5_shy[32:0];
        end
    end

    // ---- stage 6: times damping and stiffness ----
    logic               r6_v;
    t_ctx               r6_ctx;
    logic signed [63:0] r6_pd;
    logic signed [64:0] r6_kx, r6_ky;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_adv) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_ctx <= r5_ctx;
            r6_pd  <= r5_rv * $signed({1'b0, r5_ctx.damping});
            r6_kx  <= r5_shx * $signed({1'b0, r5_ctx.stiffness});
            r6_ky  <= r5_shy * $signed({1'b0, r5_ctx.stiffness});
        end
    end

    // ---- stage 7: saturate, then times time_scale ----
    logic signed [63:0] w7_d;
    logic signed [64:0] w7_kx, w7_ky;
    logic               r7_v;
    t_ctx               r7_ctx;
    logic signed [63:0] r7_md, r7_mx, r7_my;

    assign w7_d  = r6_pd >>> 16;
    assign w7_kx = r6_kx >>> 16;
    assign w7_ky = r6_ky >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (w_adv) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_ctx <= r6_ctx;
            r7_md  <= sdv_pkg::sat32({w7_d[63], w7_d}) * $signed({1'b0, r_ts});
            r7_mx  <= sdv_pkg::sat32(w7_kx) * $signed({1'b0, r_ts});
            r7_my  <= sdv_pkg::sat32(w7_ky) * $signed({1'b0, r_ts});
        end
    end

    // ---- stage 8: damping term and spring terms ----
    logic signed [63:0] w8_d, w8_x, w8_y;
    logic               r8_v;
    t_ctx               r8_ctx;
    logic signed [31:0] r8_dmp, r8_sprx, r8_spry;

    assign w8_d = r7_md >>> 16;
    assign w8_x = r7_mx >>> 16;
    assign w8_y = r7_my >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (w_adv) begin
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_ctx  <= r7_ctx;
            r8_dmp  <= sdv_pkg::sat32({w8_d[63], w8_d});
            r8_sprx <= sdv_pkg::sat32({w8_x[63], w8_x});
            r8_spry <= sdv_pkg::sat32({w8_y[63], w8_y});
        end
    end

    // ---- stage 9: damping along the direction ----
    logic               r9_v;
    t_ctx               r9_ctx;
    logic signed [49:0] r9_ex, r9_ey;
    logic signed [31:0] r9_sprx, r9_spry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (w_adv) begin
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r9_ctx  <= r8_ctx;
            r9_ex   <= r8_ctx.n_x * r8_dmp;
            r9_ey   <= r8_ctx.n_y * r8_dmp;
            r9_sprx <= r8_sprx;
            r9_spry <= r8_spry;
        end
    end

    // ---- stage 10: impulse per axis ----
    logic signed [49:0] w10_ex, w10_ey;
    logic signed [31:0] w10_jx, w10_jy;
    logic               r10_v;
    t_ctx               r10_ctx;
    logic signed [31:0] r10_jx, r10_jy;

    assign w10_ex = r9_ex >>> 16;
    assign w10_ey = r9_ey >>> 16;
    assign w10_jx = sdv_pkg::sat32({{33{r9_sprx[31]}}, r9_sprx} - {{15{w10_ex[49]}}, w10_ex});
    assign w10_jy = sdv_pkg::sat32({{33{r9_spry[31]}}, r9_spry} - {{15{w10_ey[49]}}, w10_ey});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (w_adv) begin
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r10_ctx <= r9_ctx;
            r10_jx  <= w10_jx;
            r10_jy  <= w10_jy;
        end
    end

    // ---- mass divides: |J| * 2^16 / mass ----
    logic [31:0] w_ajx, w_ajy;

    assign w_ajx = r10_jx[31] ? 32'(-r10_jx) : 32'(r10_jx);
    assign w_ajy = r10_jy[31] ? 32'(-r10_jy) : 32'(r10_jy);

    logic        w_ax_v, w_ay_v, w_bx_v, w_by_v;
    logic [47:0] w_qax, w_qay, w_qbx, w_qby;
    logic [2:0]  w_ax_side;
    logic        w_ay_sgn, w_bx_sgn, w_by_sgn;

    sdv_div #(
        .WN (48),
        .WD (31),
        .WS (3)
    ) u_div_ax (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_v     (r10_v),
        .i_num   ({w_ajx, 16'h0000}),
        .i_den   (r10_ctx.mass_a),
        .i_side  ({r10_ctx.status, r10_jx[31]}),
        .o_v     (w_ax_v),
        .o_quo   (w_qax),
        .o_side  (w_ax_side)
    );

    sdv_div #(
        .WN (48),
        .WD (31),
        .WS (1)
    ) u_div_ay (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_v     (r10_v),
        .i_num   ({w_ajy, 16'h0000}),
        .i_den   (r10_ctx.mass_a),
        .i_side  (r10_jy[31]),
        .o_v     (w_ay_v),
        .o_quo   (w_qay),
        .o_side  (w_ay_sgn)
    );

    sdv_div #(
        .WN (48),
        .WD (31),
        .WS (1)
    ) u_div_bx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_v     (r10_v),
        .i_num   ({w_ajx, 16'h0000}),
        .i_den   (r10_ctx.mass_b),
        .i_side  (r10_jx[31]),
        .o_v     (w_bx_v),
        .o_quo   (w_qbx),
        .o_side  (w_bx_sgn)
    );

    sdv_div #(
        .WN (48),
        .WD (31),
        .WS (1)
    ) u_div_by (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_v     (r10_v),
        .i_num   ({w_ajy, 16'h0000}),
        .i_den   (r10_ctx.mass_b),
        .i_side  (r10_jy[31]),
        .o_v     (w_by_v),
        .o_quo   (w_qby),
        .o_side  (w_by_sgn)
    );

    // ---- output: signs, saturation, error override ----
    sdv_pkg::t_status   w_out_status;
    sdv_pkg::t_out_item w_out;

    assign w_out_status = sdv_pkg::t_status'(w_ax_side[2:1]);

    always_comb begin
        w_out.status = w_out_status;
        if (w_out_status == sdv_pkg::ST_OK) begin
            // end A moves against J, end B with it
            w_out.dvel_a_x = sdv_pkg::sat_mag(w_qax, !w_ax_side[0]);
            w_out.dvel_a_y = sdv_pkg::sat_mag(w_qay, !w_ay_sgn);
            w_out.dvel_b_x = sdv_pkg::sat_mag(w_qbx, w_bx_sgn);
            w_out.dvel_b_y = sdv_pkg::sat_mag(w_qby, w_by_sgn);
        end else begin
            w_out.dvel_a_x = '0;
            w_out.dvel_a_y = '0;
            w_out.dvel_b_x = '0;
            w_out.dvel_b_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= w_ax_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_item <= w_out;
        end
    end

    // ---- assertions ----
    a_ndiv_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ndx_v == w_ndy_v)
        else $error("direction dividers out of step");

    a_mdiv_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ax_v == w_ay_v) && (w_ax_v == w_bx_v) && (w_ax_v == w_by_v))
        else $error("mass dividers out of step");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != sdv_pkg::ST_OK) |->
        (o_out_item.dvel_a_x == 32'sd0) && (o_out_item.dvel_a_y == 32'sd0) &&
        (o_out_item.dvel_b_x == 32'sd0) && (o_out_item.dvel_b_y == 32'sd0))
        else $error("nonzero deltas on error status");

    // a waiting output item blocks the input and stays put until taken
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |->
        !o_in_ready ##1 (o_out_valid && $stable(o_out_item)))
        else $error("output dropped or input taken during stall");

endmodule

`default_nettype wire
